[rtl/wbpm_pkg.sv]
`default_nettype none

package wbpm_pkg;

    // Defaults for the top level parameters
    localparam int PATTERN_MAX_DEF    = 32;
    localparam int POSITION_BITS_DEF  = 17;

    // Fixed field and register widths
    localparam int PATTERN_BYTES_HELD = 32;
    localparam int WORD_BYTES         = 8;
    localparam int LEN_W              = 6;
    localparam int OFFSET_W           = 16;
    localparam int CARE_W             = 32;
    localparam int CFG_DATA_W         = 64;
    localparam int CFG_INDEX_W        = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_OFFSET   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_0 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_1 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_2 = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD_3 = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 3'd6;

    // Settings seen by the cell row and the match logic
    typedef struct packed {
        logic [LEN_W-1:0]                       len_eff;
        logic [OFFSET_W-1:0]                    min_start;
        logic [PATTERN_BYTES_HELD-1:0][7:0]     pattern;
        logic [CARE_W-1:0]                      care;
    } t_match_cfg;

    // Per-request control broadcast to every cell
    typedef struct packed {
        logic step;   // a byte is taken this cycle
        logic clear;  // that byte ends the buffer
    } t_cell_ctl;

endpackage

`default_nettype wire

[rtl/wbpm_cfg_regs.sv]
`default_nettype none

module wbpm_cfg_regs
    import wbpm_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_match_cfg                  o_cfg
);

    // Usable pattern bytes: limited by the cell count and the stored bytes
    localparam int NCELL = (PATTERN_MAX < PATTERN_BYTES_HELD) ? PATTERN_MAX
                                                              : PATTERN_BYTES_HELD;

    logic [LEN_W-1:0]                   r_length;
    logic [OFFSET_W-1:0]                r_min_start;
    logic [PATTERN_BYTES_HELD-1:0][7:0] r_pattern;
    logic [CARE_W-1:0]                  r_care;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length    <= '0;
            r_min_start <= '0;
            r_pattern   <= '0;
            r_care      <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_PATTERN_LENGTH: r_length    <= i_cfg_data[LEN_W-1:0];
                REG_START_OFFSET:   r_min_start <= i_cfg_data[OFFSET_W-1:0];
                REG_PATTERN_WORD_0: r_pattern[0*WORD_BYTES +: WORD_BYTES] <= i_cfg_data;
                REG_PATTERN_WORD_1: r_pattern[1*WORD_BYTES +: WORD_BYTES] <= i_cfg_data;
                REG_PATTERN_WORD_2: r_pattern[2*WORD_BYTES +: WORD_BYTES] <= i_cfg_data;
                REG_PATTERN_WORD_3: r_pattern[3*WORD_BYTES +: WORD_BYTES] <= i_cfg_data;
                REG_CARE_MASK:      r_care      <= i_cfg_data[CARE_W-1:0];
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    // Clamp an overlong length to the cell count
    always_comb begin
        o_cfg.len_eff   = (r_length > LEN_W'(NCELL)) ? LEN_W'(NCELL) : r_length;
        o_cfg.min_start = r_min_start;
        o_cfg.pattern   = r_pattern;
        o_cfg.care      = r_care;
    end

endmodule

`default_nettype wire

[rtl/wbpm_cell.sv]
`default_nettype none

module wbpm_cell
    import wbpm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_cell_ctl       i_ctl,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_pat_byte,
    input  wire logic       i_care,
    input  wire logic       i_prev_hit,
    output logic            o_hit_next,
    output logic            o_hit
);

    // r_hit: pattern bytes 0..j match the bytes ending at the previous request
    logic r_hit;
    logic n_hit;
    logic byte_ok;

    // Wildcard or equal byte extends the neighbor's partial match
    assign byte_ok = !i_care || (i_byte == i_pat_byte);
    assign n_hit   = i_prev_hit && byte_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.step) begin
            r_hit <= i_ctl.clear ? 1'b0 : n_hit;
        end
    end

    assign o_hit_next = n_hit;
    assign o_hit      = r_hit;

endmodule

`default_nettype wire

[rtl/wildcard_byte_pattern_match.sv]
`default_nettype none

// Channel   Dir  Handshake                      Payload (lowest bit first)
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata[7:0] data_byte, tlast last_byte
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata[0] found, tdata[7:1] zero
// cfg       in   i_cfg_wr_en                    i_cfg_index, i_cfg_data
//
// One byte per cycle while s_axis_tready is high; the match decision for a byte is
// made in the cycle it is taken by the row of cells, one compare per usable pattern byte.
// A buffer's result shows on m_axis the cycle after its last byte when the output is free.
// A two-entry output (register plus skid) lets bytes keep flowing while one
// result waits; s_axis_tready drops only when both entries are full.
// Synchronous active-low reset clears the cells, position, flags and registers.

module wildcard_byte_pattern_match
    import wbpm_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // byte stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  wire logic                   s_axis_tlast,   // last_byte
    // result stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [0] found, [7:1] zero
    // configuration writes
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int NCELL = (PATTERN_MAX < PATTERN_BYTES_HELD) ? PATTERN_MAX
                                                              : PATTERN_BYTES_HELD;
    localparam int CMP_W = (POSITION_BITS + 1 > OFFSET_W + 1) ? POSITION_BITS + 1
                                                              : OFFSET_W + 1;

    t_match_cfg               cfg;
    t_cell_ctl                ctl;
    logic                     accept;
    logic                     take;
    logic [NCELL-1:0]         w_hit;
    logic [NCELL-1:0]         w_hit_next;
    logic                     len_hit;
    logic [CMP_W-1:0]         count;
    logic [CMP_W-1:0]         need;
    logic                     match;
    logic                     n_seen;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_seen;
    logic                     r_out_valid;
    logic                     r_out_found;
    logic                     r_skid_valid;
    logic                     r_skid_found;

    wbpm_cfg_regs #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign take          = r_out_valid && m_axis_tready;
    assign ctl.step      = accept;
    assign ctl.clear     = s_axis_tlast;

    // Cell row: partial match bits move one cell up with every byte
    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        logic prev_hit;
        if (j == 0) begin : g_head
            assign prev_hit = 1'b1;
        end else begin : g_link
            assign prev_hit = w_hit[j-1];
        end
        wbpm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_byte     (s_axis_tdata),
            .i_pat_byte (cfg.pattern[j]),
            .i_care     (cfg.care[j]),
            .i_prev_hit (prev_hit),
            .o_hit_next (w_hit_next[j]),
            .o_hit      (w_hit[j])
        );
    end

    // Pick the cell at the pattern length; zero length picks none
    always_comb begin
        len_hit = 1'b0;
        for (int j = 0; j < NCELL; j++) begin
            len_hit = len_hit | ((cfg.len_eff == LEN_W'(j + 1)) && w_hit_next[j]);
        end
    end

    // Start index condition: count - len >= min_start
    assign count  = CMP_W'(r_pos) + CMP_W'(1);
    assign need   = CMP_W'(cfg.len_eff) + CMP_W'(cfg.min_start);
    assign match  = len_hit && (count >= need);
    assign n_seen = r_seen || match;

    // Position counter (saturating) and sticky match flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seen <= 1'b0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                r_pos  <= '0;
                r_seen <= 1'b0;
            end else begin
                if (r_pos != {POSITION_BITS{1'b1}}) begin
                    r_pos <= r_pos + POSITION_BITS'(1);
                end
                r_seen <= n_seen;
            end
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (accept && s_axis_tlast) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_found <= r_skid_found;
            end
        end else if (accept && s_axis_tlast) begin
            if (!r_out_valid || take) begin
                r_out_found <= n_seen;
            end else begin
                r_skid_found <= n_seen;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_found};

`ifndef SYNTHESIS
    // Skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while output register is empty");

    // Input stalls only while a result is pending downstream
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !$past(m_axis_tready)))
        else $error("input stalled with no blocked result");

    // A buffer end restarts the position and match state
    a_buffer_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tlast) |=> (r_pos == '0 && !r_seen))
        else $error("per-buffer state not cleared after last byte");
`endif

endmodule

`default_nettype wire

[dv/wbpm_checker.sv]
`default_nettype none

// Watches the byte and result channels and the register port, predicts the
// found flag of every buffer and compares it with what the block returns.
module wbpm_checker
    import wbpm_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // byte channel
    input  wire logic                   i_byte_valid,
    input  wire logic                   i_byte_ready,
    input  wire logic [7:0]             i_byte_data,    // [7:0] data_byte
    input  wire logic                   i_byte_last,    // last_byte
    // result channel
    input  wire logic                   i_res_valid,
    input  wire logic                   i_res_ready,
    input  wire logic [7:0]             i_res_data,     // [0] found, [7:1] zero
    // register writes
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // status
    output int                          o_fail_count,
    output int                          o_results_owed
);

    localparam int LEN_CAP    = (PATTERN_MAX < PATTERN_BYTES_HELD) ? PATTERN_MAX
                                                                   : PATTERN_BYTES_HELD;
    localparam int WORD_COUNT = PATTERN_BYTES_HELD / WORD_BYTES;

    // Register copy
    logic [LEN_W-1:0]      len_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [CFG_DATA_W-1:0] word_reg [WORD_COUNT];
    logic [CARE_W-1:0]     care_reg;

    // Per-buffer state; window[0] holds the newest byte
    logic [7:0]               window [PATTERN_MAX];
    logic [POSITION_BITS-1:0] position;
    logic                     seen;

    // Found flags of finished buffers, oldest first
    logic found_owed [$];
    logic found_exp;
    int   fail_total = 0;

    function automatic int active_length();
        return (len_reg > LEN_CAP) ? LEN_CAP : int'(len_reg);
    endfunction

    function automatic logic [7:0] pattern_byte(int j);
        return word_reg[j / WORD_BYTES][(j % WORD_BYTES) * 8 +: 8];
    endfunction

    // Pattern byte j lines up with the byte taken len-1-j requests ago
    function automatic logic window_hit(int len);
        for (int j = 0; j < len; j++) begin
            if (care_reg[j] && window[len - 1 - j] != pattern_byte(j))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_buffer();
        for (int i = 0; i < PATTERN_MAX; i++)
            window[i] = 8'd0;
        position = '0;
        seen     = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] data, input logic last);
        int              len;
        longint unsigned count;
        len = active_length();
        for (int i = PATTERN_MAX - 1; i > 0; i--)
            window[i] = window[i - 1];
        window[0] = data;
        // bytes taken so far, this one included
        count = longint'(position) + 1;
        if (len > 0 && count >= len && count - len >= offset_reg && window_hit(len))
            seen = 1'b1;
        if (position != '1)
            position++;
        if (last) begin
            found_owed.push_back(seen);
            clear_buffer();
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_PATTERN_LENGTH: len_reg     = data[LEN_W-1:0];
            REG_START_OFFSET:   offset_reg  = data[OFFSET_W-1:0];
            REG_PATTERN_WORD_0: word_reg[0] = data;
            REG_PATTERN_WORD_1: word_reg[1] = data;
            REG_PATTERN_WORD_2: word_reg[2] = data;
            REG_PATTERN_WORD_3: word_reg[3] = data;
            REG_CARE_MASK:      care_reg    = data[CARE_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            len_reg    = '0;
            offset_reg = '0;
            care_reg   = '0;
            for (int w = 0; w < WORD_COUNT; w++)
                word_reg[w] = '0;
            clear_buffer();
            found_owed.delete();
        end else begin
            // result request: compare with the oldest buffer
            if (i_res_valid && i_res_ready) begin
                if (found_owed.size() == 0) begin
                    $error("found: no result expected, actual %0d", i_res_data[0]);
                    fail_total++;
                end else begin
                    found_exp = found_owed.pop_front();
                    if (i_res_data[0] !== found_exp) begin
                        $error("found: expected %0d, actual %0d", found_exp, i_res_data[0]);
                        fail_total++;
                    end
                    if (i_res_data[7:1] !== 7'd0) begin
                        $error("tdata[7:1]: expected 0, actual %0h", i_res_data[7:1]);
                        fail_total++;
                    end
                end
            end
            // byte request
            if (i_byte_valid && i_byte_ready)
                scan_byte(i_byte_data, i_byte_last);
            if (i_cfg_wr_en)
                write_register(i_cfg_index, i_cfg_data);
        end
        o_results_owed <= found_owed.size();
        o_fail_count   <= fail_total;
    end

endmodule

`default_nettype wire

[dv/testbench.sv]
`default_nettype none

module testbench;
    import wbpm_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;  // unmapped index
    localparam int LEN_CAP        = (PATTERN_MAX_DEF < PATTERN_BYTES_HELD) ? PATTERN_MAX_DEF
                                                                          : PATTERN_BYTES_HELD;
    localparam int PHASE_BYTES    = 517;
    localparam int LIMIT_CYCLES   = 3_000_000;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata  = 8'd0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    int                     fail_count;
    int                     results_owed;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Bytes of the buffer about to be sent
    logic [7:0] run_bytes [$];

    // Settings in force, kept to plant the pattern
    int          pat_len;
    int          pat_offset;
    logic [63:0] pat_words [4];
    logic [31:0] pat_care;

    int bytes_sent      = 0;
    int runs_sent       = 0;
    int settings_loaded = 0;

    wildcard_byte_pattern_match dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    wbpm_checker u_monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (s_axis_tvalid),
        .i_byte_ready   (s_axis_tready),
        .i_byte_data    (s_axis_tdata),
        .i_byte_last    (s_axis_tlast),
        .i_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .i_res_data     (m_axis_tdata),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_results_owed (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #(LIMIT_CYCLES * 10);
        $display("Simulation FAILED");
        $finish;
    end

    // One byte request, with random gaps before it
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_run();
        for (int i = 0; i < run_bytes.size(); i++)
            send_byte(run_bytes[i], i == run_bytes.size() - 1);
        runs_sent++;
    endtask

    // Stop sending, wait for every result and let the pipe drain
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_owed != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [63:0] len_data, input logic [63:0] offset_data,
                                 input logic [63:0] w0, input logic [63:0] w1,
                                 input logic [63:0] w2, input logic [63:0] w3,
                                 input logic [63:0] care_data);
        write_reg(REG_PATTERN_LENGTH, len_data);
        write_reg(REG_START_OFFSET, offset_data);
        write_reg(REG_PATTERN_WORD_0, w0);
        write_reg(REG_PATTERN_WORD_1, w1);
        write_reg(REG_PATTERN_WORD_2, w2);
        write_reg(REG_PATTERN_WORD_3, w3);
        write_reg(REG_CARE_MASK, care_data);
        // the unmapped index must leave everything as it is
        write_reg(REG_SPARE, {$urandom, $urandom});
        i_cfg_wr_en <= 1'b0;
        pat_len      = (len_data[LEN_W-1:0] > LEN_CAP) ? LEN_CAP : int'(len_data[LEN_W-1:0]);
        pat_offset   = int'(offset_data[OFFSET_W-1:0]);
        pat_words[0] = w0;
        pat_words[1] = w1;
        pat_words[2] = w2;
        pat_words[3] = w3;
        pat_care     = care_data[CARE_W-1:0];
        settings_loaded++;
    endtask

    // Copy the pattern into the buffer at index start, maybe with one bit off
    task automatic plant(input int start, input bit corrupt);
        int k;
        for (int j = 0; j < pat_len; j++)
            run_bytes[start + j] = pat_care[j] ? pat_words[j / 8][(j % 8) * 8 +: 8]
                                               : 8'($urandom);
        if (corrupt) begin
            k = $urandom_range(pat_len - 1);
            run_bytes[start + k] ^= 8'(1 << $urandom_range(7));
        end
    endtask

    task automatic random_settings();
        int          r;
        int          len;
        logic [63:0] len_d;
        logic [63:0] off_d;
        logic [63:0] care_d;
        r = $urandom_range(99);
        if (r < 5)       len = 0;
        else if (r < 12) len = $urandom_range(63, 33);
        else if (r < 20) len = 32;
        else if (r < 35) len = $urandom_range(31, 9);
        else             len = $urandom_range(8, 1);
        len_d = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
        len_d[LEN_W-1:0] = LEN_W'(len);

        off_d = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
        r = $urandom_range(99);
        if (r < 6)       off_d[OFFSET_W-1:0] = 16'hFFFF;
        else if (r < 12) off_d[OFFSET_W-1:0] = 16'($urandom);
        else if (r < 50) off_d[OFFSET_W-1:0] = 16'd0;
        else             off_d[OFFSET_W-1:0] = 16'($urandom_range(6, 1));

        care_d = ($urandom_range(3) == 0) ? {$urandom, $urandom} : 64'd0;
        r = $urandom_range(99);
        if (r < 10)      care_d[CARE_W-1:0] = '1;
        else if (r < 20) care_d[CARE_W-1:0] = '0;
        else             care_d[CARE_W-1:0] = $urandom;

        load_settings(len_d, off_d, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom}, care_d);
    endtask

    // Random buffer, mostly with the pattern planted somewhere in it
    task automatic random_run();
        int n;
        int j;
        if (pat_offset > 64)
            n = $urandom_range(24, 1);
        else if ($urandom_range(9) == 0)
            n = $urandom_range(3, 1);
        else
            n = $urandom_range(pat_len + pat_offset + 8, 1);
        run_bytes.delete();
        repeat (n) begin
            // pattern bytes in the noise give near misses
            j = $urandom_range(31);
            run_bytes.push_back($urandom_range(1) ? 8'($urandom)
                                                  : pat_words[j / 8][(j % 8) * 8 +: 8]);
        end
        if (pat_len > 0 && n >= pat_len && $urandom_range(9) < 7)
            plant($urandom_range(n - pat_len), $urandom_range(3) == 0);
        send_run();
    endtask

    task automatic random_phase(input int s_pct, input int r_pct, input int budget);
        int first;
        send_idle_pct <= s_pct;
        recv_idle_pct <= r_pct;
        first = bytes_sent;
        while (bytes_sent - first < budget) begin
            settle();
            random_settings();
            repeat ($urandom_range(6, 2)) random_run();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct <= 25;
        recv_idle_pct <= 65;
        @(posedge i_clk);

        // Reset settings: empty pattern never matches
        run_bytes = '{8'hFF, 8'h00};
        send_run();

        // Three bytes, middle one a wildcard; then a buffer one byte short
        settle();
        load_settings(64'd3, 64'd0, 64'h0000_0000_0033_2211, 64'd0, 64'd0, 64'd0, 64'h5);
        run_bytes = '{8'h11, 8'hEE, 8'h33};
        send_run();
        run_bytes = '{8'h11, 8'h22};
        send_run();

        // Start offset one: a match at index zero no longer counts
        settle();
        load_settings(64'd3, 64'd1, 64'h0000_0000_0033_2211, 64'd0, 64'd0, 64'd0, 64'h5);
        run_bytes = '{8'h11, 8'h00, 8'h33, 8'hFF};
        send_run();
        run_bytes = '{8'hFF, 8'h11, 8'h5A, 8'h33};
        send_run();

        // Extreme byte values in the pattern
        settle();
        load_settings(64'd2, 64'd0, 64'h0000_0000_0000_00FF, 64'd0, 64'd0, 64'd0, 64'h3);
        run_bytes = '{8'h00, 8'hFF, 8'h00};
        send_run();

        random_phase(25, 65, PHASE_BYTES);
        random_phase(65, 25, PHASE_BYTES);
        random_phase(0, 0, PHASE_BYTES);

        settle();
        $display("Sent %0d bytes in %0d buffers over %0d register settings,",
                 bytes_sent, runs_sent, settings_loaded);
        $display("with idle mixes 25/65, 65/25 and none, plus directed wildcard and offset cases.");
        if (fail_count == 0 && results_owed == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/wbpm_pkg.sv
rtl/wbpm_cfg_regs.sv
rtl/wbpm_cell.sv
rtl/wildcard_byte_pattern_match.sv
dv/wbpm_checker.sv
dv/testbench.sv
